### hw/rtl/quotient_filter_insert_query_core_defines.svh
// Assertion macros for the quotient filter core RTL.
`ifndef QUOTIENT_FILTER_INSERT_QUERY_CORE_DEFINES_SVH
`define QUOTIENT_FILTER_INSERT_QUERY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define QF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/qf_pkg.sv
// Shared types and constants for the quotient filter.
`timescale 1ns / 1ps
`default_nettype none
package qf_pkg;
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic        REQ_INSERT = 1'b0;
    localparam logic        REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [10:0] slot_index;
        logic        overflow;
    } t_rsp;

    // hash unit to control: finished hash
    typedef struct packed {
        logic        valid;
        logic        req_type;
        logic [31:0] hash;
    } t_hash_res;
endpackage
`default_nettype wire

### hw/rtl/qf_hash.sv
// Byte-serial FNV-1 hash, one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qf_hash
    import qf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_req      i_req,
    output t_hash_res      o_res
);
    logic [31:0] r_h, n_h;
    logic [31:0] r_key;
    logic        r_type;
    logic [2:0]  r_cnt;
    logic        r_busy, r_done;
    logic [31:0] w_prod;

    assign w_prod = r_h * FNV_PRIME;
    assign n_h = w_prod ^ {24'd0, r_key[31:24]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h    <= FNV_OFFSET;
            r_key  <= i_req.key;
            r_type <= i_req.req_type;
        end else if (r_busy) begin
            r_h   <= n_h;
            r_key <= {r_key[23:0], 8'd0};
        end
    end

    assign o_res.valid    = r_done;
    assign o_res.req_type = r_type;
    assign o_res.hash     = r_h;
endmodule
`default_nettype wire

### hw/rtl/quotient_filter_insert_query_core.sv
// Quotient filter: one slot memory with a read/modify/write sequencer.
//
// Input channel i_req_valid / o_req_stall carries one beat per insert or
// query (t_req). Output channel o_rsp_valid / i_rsp_stall returns one
// beat (t_rsp) per request, in order.
// One request is worked at a time. A request is first hashed, then
// each slot read on the single-port slot memory goes through S_RD:
// the backward walk to the cluster start, the forward walk to the run,
// the scan of the run and the search for an empty slot. Each slot moved
// by the shift passes through S_WAIT, S_RD and S_SHIFT. The next beat
// is taken once the result has moved to the output register and the
// sequencer is back in S_IDLE; long clusters take longer.
// After reset the sequencer clears every slot, one per cycle, all
// 2^QUOTIENT_BITS + EXTRA_SLOTS of them (1152 at the defaults), and holds
// o_req_stall high until done.
// A finished response waits in an output register while the receiver
// stalls; the next request is accepted while it waits, and its result
// is held back until the earlier beat is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "quotient_filter_insert_query_core_defines.svh"
module quotient_filter_insert_query_core
    import qf_pkg::*;
#(
    parameter int QUOTIENT_BITS  = 10,
    parameter int REMAINDER_BITS = 8,
    parameter int EXTRA_SLOTS    = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);
    localparam int NSLOTS = (1 << QUOTIENT_BITS) + EXTRA_SLOTS;
    localparam int AW     = $clog2(NSLOTS + 2);
    localparam int EW     = REMAINDER_BITS + 3;
    localparam logic [AW-1:0] LAST = AW'(NSLOTS - 1);
    localparam logic [AW-1:0] NS   = AW'(NSLOTS);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'h0001, S_IDLE   = 15'h0002, S_HASH   = 15'h0004,
        S_CANON  = 15'h0008, S_BACK   = 15'h0010, S_FWD_S  = 15'h0020,
        S_FWD_B  = 15'h0040, S_SCAN   = 15'h0080, S_SCAN_C = 15'h0100,
        S_EMPTY  = 15'h0200, S_SHIFT  = 15'h0400, S_RSP    = 15'h0800,
        S_WAIT   = 15'h1000, S_SETCN  = 15'h2000, S_RD     = 15'h4000
    } t_state;

    // memory
    logic [EW-1:0] r_mem [NSLOTS];
    logic [EW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr[$clog2(NSLOTS)-1:0]] <= mem_wdata;
        r_rdata <= r_mem[mem_addr[$clog2(NSLOTS)-1:0]];
    end

    t_state r_st, n_st, r_ret, n_ret;
    logic [AW-1:0] r_a, n_a, r_b, n_b, r_s, n_s, r_rs, n_rs, r_fq, n_fq;
    logic [REMAINDER_BITS-1:0] r_fr, n_fr;
    logic [EW-1:0] r_canon, n_canon, r_cur, n_cur;
    logic r_type, n_type, r_occ, n_occ;
    t_rsp r_res, n_res;
    logic r_ovalid, n_ovalid;
    t_rsp r_out, n_out;
    logic hstart;
    t_hash_res hres;
    logic [EW-1:0] rd_e;   // data of r_a, beyond-store reads as empty

    qf_hash u_hash (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(hstart),
                    .i_req(i_req), .o_res(hres));

    assign o_req_stall = (r_st != S_IDLE);
    assign hstart      = i_req_valid && !o_req_stall;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_out;
    assign rd_e        = (r_a < NS) ? r_rdata : '0;

    // a read is issued by setting mem_addr and going to S_RD, which continues in state r_ret
    always_comb begin
        n_st = r_st; n_ret = r_ret; n_a = r_a; n_b = r_b; n_s = r_s;
        n_rs = r_rs; n_fq = r_fq; n_fr = r_fr; n_canon = r_canon;
        n_cur = r_cur; n_type = r_type; n_occ = r_occ;
        n_res = r_res; n_ovalid = r_ovalid; n_out = r_out;
        mem_we = 1'b0; mem_addr = r_a; mem_wdata = '0;
        if (r_ovalid && !i_rsp_stall) n_ovalid = 1'b0;
        unique case (r_st)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_a = r_a + 1'b1;
                if (r_a == LAST) n_st = S_IDLE;
            end
            S_IDLE: if (hstart) n_st = S_HASH;
            S_HASH: if (hres.valid) begin
                n_type = hres.req_type;
                n_fr = hres.hash[REMAINDER_BITS-1:0];
                n_fq = AW'(hres.hash[REMAINDER_BITS +: QUOTIENT_BITS]);
                n_a = AW'(hres.hash[REMAINDER_BITS +: QUOTIENT_BITS]);
                mem_addr = n_a; n_st = S_RD; n_ret = S_CANON;
            end
            S_RD: n_st = r_ret;   // read data lands next cycle
            S_CANON: begin
                n_canon = r_rdata;
                n_occ = r_rdata[2];
                if (r_type == REQ_QUERY) begin
                    if (!r_rdata[2]) begin
                        n_res = '0; n_st = S_RSP;
                    end else begin
                        n_b = r_fq; mem_addr = r_fq; n_st = S_RD; n_ret = S_BACK;
                    end
                end else if (r_rdata[2:0] == 3'd0) begin
                    mem_we = 1'b1; mem_addr = r_fq;
                    mem_wdata = {r_fr, 3'b100};
                    n_res = '{hit: 1'b0, slot_index: 11'(r_fq), overflow: 1'b0};
                    n_st = S_RSP;
                end else begin
                    mem_we = 1'b1; mem_addr = r_fq;
                    mem_wdata = r_rdata | EW'(4);
                    n_b = r_fq; n_st = S_WAIT; n_ret = S_BACK;
                end
            end
            S_WAIT: begin mem_addr = r_b; n_a = r_b; n_st = S_RD; end
            S_BACK: begin
                // r_a == r_b here
                if (r_b != '0 && rd_e[0]) begin
                    n_b = r_b - 1'b1; n_a = n_b; mem_addr = n_b;
                    n_st = S_RD; n_ret = S_BACK;
                end else begin
                    n_s = r_b;
                    if (r_b == r_fq) begin
                        n_rs = r_b; n_st = S_SCAN;
                        n_a = r_b; mem_addr = r_b; n_st = S_RD; n_ret = S_SCAN;
                    end else begin
                        n_s = r_b + 1'b1; n_a = n_s; mem_addr = n_s;
                        n_st = S_RD; n_ret = S_FWD_S;
                    end
                end
            end
            S_FWD_S: begin
                if (r_s < NS && rd_e[1]) begin
                    n_s = r_s + 1'b1; n_a = n_s; mem_addr = n_s;
                    n_st = S_RD; n_ret = S_FWD_S;
                end else begin
                    n_b = r_b + 1'b1; n_a = n_b; mem_addr = n_b;
                    n_st = S_RD; n_ret = S_FWD_B;
                end
            end
            S_FWD_B: begin
                if (r_b != r_fq && !rd_e[2]) begin
                    n_b = r_b + 1'b1; n_a = n_b; mem_addr = n_b;
                    n_st = S_RD; n_ret = S_FWD_B;
                end else if (r_b == r_fq) begin
                    n_rs = r_s; n_a = r_s; mem_addr = r_s;
                    n_st = S_RD; n_ret = S_SCAN;
                end else begin
                    n_s = r_s + 1'b1; n_a = n_s; mem_addr = n_s;
                    n_st = S_RD; n_ret = S_FWD_S;
                end
            end
            S_SCAN: begin
                if (r_type == REQ_INSERT && !r_occ) begin
                    n_a = r_s; mem_addr = r_s; n_st = S_RD; n_ret = S_EMPTY;
                end else if (rd_e[EW-1:3] == r_fr) begin
                    n_res = '{hit: 1'b1, slot_index: 11'(r_s), overflow: 1'b0};
                    if (r_type == REQ_INSERT) begin
                        mem_we = 1'b1; mem_addr = r_fq; mem_wdata = r_canon;
                    end
                    n_st = S_RSP;
                end else if (rd_e[EW-1:3] > r_fr) begin
                    // past the sorted position: a query misses, an insert goes here
                    if (r_type == REQ_QUERY) begin
                        n_res = '0; n_st = S_RSP;
                    end else begin
                        n_a = r_s; mem_addr = r_s; n_st = S_RD; n_ret = S_EMPTY;
                    end
                end else begin
                    n_s = r_s + 1'b1; n_a = n_s; mem_addr = n_s;
                    n_st = S_RD; n_ret = S_SCAN_C;
                end
            end
            S_SCAN_C: begin
                if (r_s < NS && rd_e[1]) begin
                    n_st = S_SCAN;
                end else if (r_type == REQ_QUERY) begin
                    n_res = '0; n_st = S_RSP;
                end else begin
                    n_a = r_s; mem_addr = r_s; n_st = S_RD; n_ret = S_EMPTY;
                end
            end
            S_EMPTY: begin
                if (r_a >= NS) begin
                    mem_we = 1'b1; mem_addr = r_fq; mem_wdata = r_canon;
                    n_res = '{hit: 1'b0, slot_index: 11'd0, overflow: 1'b1};
                    n_st = S_RSP;
                end else if (rd_e[2:0] != 3'd0) begin
                    n_a = r_a + 1'b1; mem_addr = n_a; n_st = S_RD; n_ret = S_EMPTY;
                end else begin
                    n_cur = {r_fr, 3'b000};
                    if (r_occ && r_s != r_rs) n_cur[1] = 1'b1;
                    if (r_s != r_fq) n_cur[0] = 1'b1;
                    n_res = '{hit: 1'b0, slot_index: 11'(r_s), overflow: 1'b0};
                    if (r_occ && r_s == r_rs) begin
                        n_a = r_rs; mem_addr = r_rs; n_st = S_RD; n_ret = S_SETCN;
                    end else begin
                        n_a = r_s; mem_addr = r_s; n_st = S_RD; n_ret = S_SHIFT;
                    end
                end
            end
            S_SETCN: begin
                // slot rs gets continuation before it is shifted
                n_canon = r_rdata | EW'(2);
                n_a = r_s; mem_addr = r_s; n_st = S_SHIFT; n_ret = S_SHIFT;
                n_b = '1; // flag: use patched data
            end
            S_SHIFT: begin
                // r_rdata holds the old contents of r_a
                logic [EW-1:0] prev;
                logic          last;
                prev = (r_b == '1 && r_ret == S_SHIFT && r_a == r_rs) ? r_canon : r_rdata;
                if (r_b == '1) prev = r_canon;
                // stop after the slot that was empty before the move, or at the last slot
                last = (prev[2:0] == 3'd0) || (r_a == LAST);
                mem_we = 1'b1; mem_addr = r_a;
                mem_wdata = r_cur;
                n_b = '0;
                if (prev[2]) begin
                    mem_wdata[2] = 1'b1;
                    prev[2] = 1'b0;
                end
                n_cur = prev | EW'(1);
                if (last) begin
                    n_st = S_RSP;
                end else begin
                    n_a = r_a + 1'b1; n_st = S_WAIT; n_ret = S_SHIFT;
                    n_b = r_a + 1'b1;
                end
            end
            S_RSP: if (!r_ovalid || !i_rsp_stall) begin
                n_ovalid = 1'b1; n_out = r_res; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_WAIT && r_ret == S_SHIFT) begin
            mem_addr = r_b; n_a = r_b; n_b = '0; n_st = S_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_ret <= S_IDLE; r_a <= '0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st; r_ret <= n_ret; r_a <= n_a; r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b; r_s <= n_s; r_rs <= n_rs; r_fq <= n_fq; r_fr <= n_fr;
        r_canon <= n_canon; r_cur <= n_cur; r_type <= n_type; r_occ <= n_occ;
        r_res <= n_res; r_out <= n_out;
    end

    `QF_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_st == S_CLEAR, o_req_stall)
    `QF_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall,
                    o_rsp_valid && $stable(o_rsp))
    `QF_ASSERT_IMPL(a_ovf_clean, i_clk, i_rst_n, o_rsp_valid && o_rsp.overflow,
                    !o_rsp.hit && o_rsp.slot_index == 11'd0)
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the quotient filter insert/query core.
`timescale 1ns / 1ps
module tb;
    import qf_pkg::*;

    localparam int QBITS   = 10;
    localparam int RBITS   = 8;
    localparam int NSLOT   = (1 << QBITS) + 128;
    localparam int F_OCC   = 4;
    localparam int F_CONT  = 2;
    localparam int F_SHIFT = 1;
    localparam int CYCLE_LIMIT = 80000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    quotient_filter_insert_query_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter mirror
    logic [RBITS+2:0] slots [NSLOT];
    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   send_idle_pct = 7;
    int   recv_idle_pct = 66;
    int   hold_off = 0;
    int   errors = 0;
    int   n_sent = 0;
    int   n_rsp = 0;
    int   n_hits = 0;
    int   n_ovf = 0;
    int   cycles = 0;

    function automatic logic [RBITS+2:0] slot_rd(int i);
        return (i < NSLOT) ? slots[i] : '0;
    endfunction

    function automatic logic [31:0] key_hash(logic [31:0] k);
        logic [31:0] h;
        h = FNV_OFFSET;
        for (int i = 0; i < 4; i++)
            h = (h * FNV_PRIME) ^ {24'd0, k[31-8*i -: 8]};
        return h;
    endfunction

    function automatic int find_run(int fq);
        int b, s;
        b = fq;
        while (b > 0 && (slot_rd(b) & F_SHIFT)) b--;
        s = b;
        while (b != fq) begin
            do s++; while (s < NSLOT && (slot_rd(s) & F_CONT));
            do b++; while (b != fq && !(slot_rd(b) & F_OCC));
        end
        return s;
    endfunction

    function automatic t_rsp filter_apply(t_req r);
        t_rsp res;
        logic [31:0] h;
        int fq, fr, s, rs, e, idx, rem;
        logic [RBITS+2:0] canon, cur, prv, newe;
        logic orig_occ, done;
        res = '0;
        h = key_hash(r.key);
        fq = (h >> RBITS) & ((1 << QBITS) - 1);
        fr = h & ((1 << RBITS) - 1);
        canon = slot_rd(fq);
        if (r.req_type == REQ_QUERY) begin
            if (!(canon & F_OCC)) return res;
            s = find_run(fq);
            do begin
                rem = slot_rd(s) >> 3;
                if (rem == fr) begin
                    res.hit = 1'b1;
                    res.slot_index = s[10:0];
                    return res;
                end
                if (rem > fr) break;
                s++;
            end while (s < NSLOT && (slot_rd(s) & F_CONT));
            return res;
        end
        newe = fr << 3;
        if (canon[2:0] == 3'd0) begin
            slots[fq] = newe | F_OCC;
            res.slot_index = fq[10:0];
            return res;
        end
        orig_occ = (canon & F_OCC) != 0;
        slots[fq] = canon | F_OCC;
        rs = find_run(fq);
        s = rs;
        if (orig_occ) begin
            do begin
                rem = slot_rd(s) >> 3;
                if (rem == fr) begin
                    res.hit = 1'b1;
                    res.slot_index = s[10:0];
                    return res;
                end
                if (rem > fr) break;
                s++;
            end while (s < NSLOT && (slot_rd(s) & F_CONT));
        end
        e = s;
        while (e < NSLOT && (slot_rd(e) & 7) != 0) e++;
        if (e >= NSLOT) begin
            slots[fq] = canon;
            res.overflow = 1'b1;
            return res;
        end
        if (orig_occ) begin
            if (s == rs) slots[rs] = slots[rs] | F_CONT;
            else newe = newe | F_CONT;
        end
        if (s != fq) newe = newe | F_SHIFT;
        idx = s;
        cur = newe;
        done = 1'b0;
        while (!done && idx < NSLOT) begin
            prv = slots[idx];
            done = prv[2:0] == 3'd0;
            prv = prv | F_SHIFT;
            if (prv & F_OCC) begin
                prv = prv & ~F_OCC;
                cur = cur | F_OCC;
            end
            slots[idx] = cur;
            cur = prv;
            idx++;
        end
        res.slot_index = s[10:0];
        return res;
    endfunction

    // driver: predict at acceptance so the mirror follows the block's order
    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && !o_req_stall) begin
            expected_rsps.push_back(filter_apply(i_req));
            n_sent++;
        end
        if (!i_req_valid || (i_rst_n && !o_req_stall)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_req <= pending_reqs.pop_front();
                i_req_valid <= 1'b1;
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
                $display("%0t unexpected beat %p", $time, o_rsp);
                errors++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                n_hits += exp_rsp.hit;
                n_ovf += exp_rsp.overflow;
                if (o_rsp.hit !== exp_rsp.hit)
                    $display("%0t hit exp %0d got %0d", $time, exp_rsp.hit, o_rsp.hit);
                if (o_rsp.slot_index !== exp_rsp.slot_index)
                    $display("%0t slot exp %0d got %0d", $time, exp_rsp.slot_index,
                             o_rsp.slot_index);
                if (o_rsp.overflow !== exp_rsp.overflow)
                    $display("%0t overflow exp %0d got %0d", $time, exp_rsp.overflow,
                             o_rsp.overflow);
                if (o_rsp !== exp_rsp) errors++;
            end
        end
    end

    // receiver stall, with a counted hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic add_req(logic typ, logic [31:0] k);
        t_req r;
        r.req_type = typ;
        r.key = k;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drain();
        while (pending_reqs.size() > 0 || i_req_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    // keys mostly from a small pool so inserts repeat and queries hit
    task automatic add_random(int n, int pool);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                add_req(1'($urandom_range(1)), $urandom());
            else
                add_req(1'($urandom_range(1)), $urandom_range(pool));
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) slots[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-table query, extremes, repeat insert, hit and miss queries
        add_req(REQ_QUERY, 32'h0);
        add_req(REQ_INSERT, 32'h0);
        add_req(REQ_INSERT, 32'h0);
        add_req(REQ_QUERY, 32'h0);
        add_req(REQ_INSERT, 32'hFFFF_FFFF);
        add_req(REQ_QUERY, 32'hFFFF_FFFF);
        add_req(REQ_QUERY, 32'h8000_0000);
        for (int i = 1; i <= 12; i++) add_req(REQ_INSERT, 32'h1 << (i * 2));
        for (int i = 1; i <= 5; i++) add_req(REQ_QUERY, 32'h1 << (i * 2));

        add_random(400, 3000);
        // long hold-off while the sender keeps offering beats
        pending_reqs.push_back('0);
        while (pending_reqs.size() > 0) @(posedge i_clk);
        hold_off = 400;
        add_random(100, 3000);
        wait_drain();

        send_idle_pct = 66;
        recv_idle_pct = 7;
        add_random(450, 1000);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // fill toward the end of the table to reach overflow
        add_random(580, 200000);
        wait_drain();
        repeat (100) @(posedge i_clk);

        $display("sent %0d requests, %0d responses, %0d hits, %0d overflows",
                 n_sent, n_rsp, n_hits, n_ovf);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("errors %0d, left over %0d", errors, expected_rsps.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/qf_pkg.sv
hw/rtl/qf_hash.sv
hw/rtl/quotient_filter_insert_query_core.sv
bench/tb.sv
